// File: design/least_squares_plane_fit_defines.svh
// Assertion macros used by the checker file of the plane fit block.
`ifndef LEAST_SQUARES_PLANE_FIT_DEFINES_SVH
`define LEAST_SQUARES_PLANE_FIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define LSPF_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("plane fit check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define LSPF_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("plane fit check failed");

`endif

// File: design/lspf_pkg.sv
package lspf_pkg;

    localparam int MAX_POINTS = 65536;
    localparam int COORD_W    = 16;
    localparam int SQ_W       = 48;
    localparam int LIN_W      = 34;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PROD_W     = 2 * COORD_W;
    localparam int COEF_W     = 32;

    // Matrix entry, pair difference, product, determinant, dividend, remainder.
    localparam int MW  = SQ_W;
    localparam int PW  = 2 * MW + 1;
    localparam int RW  = MW + PW;
    localparam int DW  = RW + 2;
    localparam int NW  = DW + 18;
    localparam int RMW = DW + 2;
    localparam int IT_W = $clog2(NW);

    localparam int STEP_W    = 4;
    localparam int LAST_STEP = 8;
    localparam int SH_AB     = 17;
    localparam int SH_C      = 9;

    typedef enum logic [1:0] {PH_A, PH_B, PH_C, PH_DET} phase_t;

    typedef enum logic [2:0] {WB_T, WB_D, WB_LOAD, WB_SUB, WB_ADD} wb_kind_t;

    typedef struct packed {
        logic                acc_en;
        logic                solve_start;
        logic                mul_load;
        logic                mul_step;
        logic                mul_last;
        logic                mul_wb;
        logic                abs_en;
        logic                div_load;
        logic                div_step;
        logic                div_wb;
        logic                out_load;
        logic [STEP_W-1:0]   step;
        phase_t              phase;
    } lspf_cmd_t;

    typedef struct packed {
        logic det_zero;
    } lspf_sts_t;

    // Entries are numbered row * 3 + column.
    function automatic logic [3:0] step_a_idx(input logic [STEP_W-1:0] step);
        logic [3:0] idx;
        case (step) inside
            4'd0, 4'd7: idx = 4'd4;
            4'd1, 4'd4: idx = 4'd5;
            4'd2:       idx = 4'd0;
            4'd3, 4'd6: idx = 4'd3;
            4'd5:       idx = 4'd1;
            default:    idx = 4'd2;
        endcase
        return idx;
    endfunction

    function automatic logic [3:0] step_b_idx(input logic [STEP_W-1:0] step);
        logic [3:0] idx;
        case (step) inside
            4'd1, 4'd6: idx = 4'd7;
            4'd4, 4'd7: idx = 4'd6;
            default:    idx = 4'd8;
        endcase
        return idx;
    endfunction

    function automatic wb_kind_t step_kind(input logic [STEP_W-1:0] step);
        wb_kind_t k;
        case (step) inside
            4'd0, 4'd3, 4'd6: k = WB_T;
            4'd1, 4'd4, 4'd7: k = WB_D;
            4'd2:             k = WB_LOAD;
            4'd5:             k = WB_SUB;
            default:          k = WB_ADD;
        endcase
        return k;
    endfunction

endpackage

// File: design/lspf_ctrl.sv
module lspf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_point,
    input  logic                out_stall,
    input  lspf_pkg::lspf_sts_t sts,
    output logic                in_stall,
    output logic                out_valid,
    output lspf_pkg::lspf_cmd_t cmd
);
    import lspf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_LOAD, S_MUL_RUN, S_MUL_WB, S_ABS, S_CHECK,
        S_DIV_LOAD, S_DIV_RUN, S_DIV_WB, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    phase_t              phase_reg, phase_next;
    logic [IT_W-1:0]     cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.phase  = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.acc_en = accept;
                if (accept && last_point)
                begin
                    cmd.solve_start = 1'b1;
                    phase_next      = PH_DET;
                    step_next       = '0;
                    state_next      = S_MUL_LOAD;
                end
            end
            S_MUL_LOAD:
            begin
                cmd.mul_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_MUL_RUN;
            end
            S_MUL_RUN:
            begin
                cmd.mul_step = 1'b1;
                cmd.mul_last = (cnt_reg == IT_W'(MW - 1));
                cnt_next     = cnt_reg + 1'b1;
                if (cmd.mul_last)
                begin
                    state_next = S_MUL_WB;
                end
            end
            S_MUL_WB:
            begin
                cmd.mul_wb = 1'b1;
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = S_ABS;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_MUL_LOAD;
                end
            end
            S_ABS:
            begin
                cmd.abs_en = 1'b1;
                state_next = (phase_reg == PH_DET) ? S_CHECK : S_DIV_LOAD;
            end
            S_CHECK:
            begin
                if (sts.det_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    phase_next = PH_A;
                    step_next  = '0;
                    state_next = S_MUL_LOAD;
                end
            end
            S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == IT_W'(NW - 1))
                begin
                    state_next = S_DIV_WB;
                end
            end
            S_DIV_WB:
            begin
                cmd.div_wb = 1'b1;
                if (phase_reg == PH_C)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    phase_next = phase_t'(phase_reg + 1'b1);
                    step_next  = '0;
                    state_next = S_MUL_LOAD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            phase_reg     <= PH_DET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/lspf_dp.sv
module lspf_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lspf_pkg::lspf_cmd_t                   cmd,
    input  logic signed [lspf_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [lspf_pkg::COORD_W-1:0]   y_coord,
    input  logic signed [lspf_pkg::COORD_W-1:0]   z_coord,
    output lspf_pkg::lspf_sts_t                   sts,
    output logic signed [lspf_pkg::COEF_W-1:0]    a_coef,
    output logic signed [lspf_pkg::COEF_W-1:0]    b_coef,
    output logic signed [lspf_pkg::COEF_W-1:0]    c_coef,
    output logic                                  solvable,
    output logic                                  overflow
);
    import lspf_pkg::*;

    logic signed [SQ_W-1:0]   sxx_reg, sxy_reg, syy_reg, sxz_reg, syz_reg;
    logic signed [LIN_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     dropped_reg;
    logic signed [PROD_W-1:0] pxx, pxy, pyy, pxz, pyz;

    logic signed [MW-1:0]     base [9];
    logic signed [MW-1:0]     rhsv [3];
    logic signed [MW-1:0]     ent  [9];
    logic signed [MW-1:0]     a_op;
    logic signed [PW-1:0]     b_op;
    wb_kind_t                 kind;

    logic [MW-1:0]            a_sh_reg;
    logic signed [RW-1:0]     b_sh_reg, prod_reg;
    logic signed [PW-1:0]     t_reg, d_reg;
    logic signed [DW-1:0]     acc_reg, acc_mag;
    logic [DW-1:0]            det_abs_reg;
    logic                     det_neg_reg, det_zero_reg, num_neg_reg;

    logic [NW-1:0]            n_reg;
    logic [RMW-1:0]           r_reg, r_sh, d2;
    logic                     ge;
    logic [COEF_W-1:0]        q_reg, lim, mag, res;
    logic                     over_reg, neg;

    logic signed [COEF_W-1:0] ca_reg, cb_reg, cc_reg;
    logic                     solv_reg;
    logic signed [COEF_W-1:0] a_out_reg, b_out_reg, c_out_reg;
    logic                     solv_out_reg, over_out_reg;

    assign pxx = x_coord * x_coord;
    assign pxy = x_coord * y_coord;
    assign pyy = y_coord * y_coord;
    assign pxz = x_coord * z_coord;
    assign pyz = y_coord * z_coord;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxx_reg <= '0; sxy_reg <= '0; syy_reg <= '0; sxz_reg <= '0; syz_reg <= '0;
            sx_reg  <= '0; sy_reg  <= '0; sz_reg  <= '0;
            cnt_reg <= '0; dropped_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            sxx_reg <= '0; sxy_reg <= '0; syy_reg <= '0; sxz_reg <= '0; syz_reg <= '0;
            sx_reg  <= '0; sy_reg  <= '0; sz_reg  <= '0;
            cnt_reg <= '0; dropped_reg <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (cnt_reg < CNT_W'(MAX_POINTS))
            begin
                sxx_reg <= sxx_reg + SQ_W'(pxx);
                sxy_reg <= sxy_reg + SQ_W'(pxy);
                syy_reg <= syy_reg + SQ_W'(pyy);
                sxz_reg <= sxz_reg + SQ_W'(pxz);
                syz_reg <= syz_reg + SQ_W'(pyz);
                sx_reg  <= sx_reg + LIN_W'(x_coord);
                sy_reg  <= sy_reg + LIN_W'(y_coord);
                sz_reg  <= sz_reg + LIN_W'(z_coord);
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                dropped_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        base[0] = sxx_reg;
        base[1] = sxy_reg;
        base[2] = MW'(sx_reg);
        base[3] = sxy_reg;
        base[4] = syy_reg;
        base[5] = MW'(sy_reg);
        base[6] = MW'(sx_reg);
        base[7] = MW'(sy_reg);
        base[8] = signed'(MW'(cnt_reg));
        rhsv[0] = sxz_reg;
        rhsv[1] = syz_reg;
        rhsv[2] = MW'(sz_reg);
        for (int i = 0; i < 9; i++)
        begin
            ent[i] = (2'(i % 3) == cmd.phase) ? rhsv[i / 3] : base[i];
        end
    end

    assign kind = step_kind(cmd.step);
    assign a_op = ent[step_a_idx(cmd.step)];
    assign b_op = (kind == WB_T || kind == WB_D) ? PW'(ent[step_b_idx(cmd.step)]) : d_reg;

    assign acc_mag = acc_reg[DW-1] ? -acc_reg : acc_reg;

    assign d2   = RMW'({det_abs_reg, 1'b0});
    assign r_sh = {r_reg[RMW-2:0], n_reg[NW-1]};
    assign ge   = (r_sh >= d2);

    assign neg = num_neg_reg ^ det_neg_reg;
    assign lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign mag = (over_reg || (q_reg > lim)) ? lim : q_reg;
    assign res = neg ? (~mag + 1'b1) : mag;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            a_sh_reg <= a_op;
            b_sh_reg <= RW'(b_op);
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (a_sh_reg[0])
            begin
                prod_reg <= prod_reg + (cmd.mul_last ? -b_sh_reg : b_sh_reg);
            end
            a_sh_reg <= a_sh_reg >> 1;
            b_sh_reg <= b_sh_reg <<< 1;
        end

        if (cmd.mul_wb)
        begin
            case (kind)
                WB_T:    t_reg   <= prod_reg[PW-1:0];
                WB_D:    d_reg   <= t_reg - prod_reg[PW-1:0];
                WB_LOAD: acc_reg <= DW'(prod_reg);
                WB_SUB:  acc_reg <= acc_reg - DW'(prod_reg);
                WB_ADD:  acc_reg <= acc_reg + DW'(prod_reg);
                default: t_reg   <= t_reg;
            endcase
        end
        else if (cmd.abs_en)
        begin
            if (cmd.phase == PH_DET)
            begin
                det_abs_reg <= $unsigned(acc_mag);
                det_neg_reg <= acc_reg[DW-1];
            end
            else
            begin
                acc_reg     <= acc_mag;
                num_neg_reg <= acc_reg[DW-1];
            end
        end

        if (cmd.div_load)
        begin
            if (cmd.phase == PH_C)
            begin
                n_reg <= (NW'($unsigned(acc_reg)) << SH_C) + NW'(det_abs_reg);
            end
            else
            begin
                n_reg <= (NW'($unsigned(acc_reg)) << SH_AB) + NW'(det_abs_reg);
            end
            r_reg    <= '0;
            q_reg    <= '0;
            over_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            n_reg    <= n_reg << 1;
            r_reg    <= ge ? (r_sh - d2) : r_sh;
            q_reg    <= {q_reg[COEF_W-2:0], ge};
            over_reg <= over_reg | q_reg[COEF_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_zero_reg <= 1'b0;
            ca_reg       <= '0;
            cb_reg       <= '0;
            cc_reg       <= '0;
            solv_reg     <= 1'b0;
            a_out_reg    <= '0;
            b_out_reg    <= '0;
            c_out_reg    <= '0;
            solv_out_reg <= 1'b0;
            over_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.abs_en && cmd.phase == PH_DET)
            begin
                det_zero_reg <= (acc_reg == '0);
            end
            if (cmd.solve_start)
            begin
                ca_reg   <= '0;
                cb_reg   <= '0;
                cc_reg   <= '0;
                solv_reg <= 1'b0;
            end
            else if (cmd.div_wb)
            begin
                case (cmd.phase)
                    PH_A:    ca_reg <= signed'(res);
                    PH_B:    cb_reg <= signed'(res);
                    PH_C:
                    begin
                        cc_reg   <= signed'(res);
                        solv_reg <= 1'b1;
                    end
                    default: solv_reg <= solv_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                a_out_reg    <= ca_reg;
                b_out_reg    <= cb_reg;
                c_out_reg    <= cc_reg;
                solv_out_reg <= solv_reg;
                over_out_reg <= dropped_reg;
            end
        end
    end

    assign sts.det_zero = det_zero_reg;
    assign a_coef   = a_out_reg;
    assign b_coef   = b_out_reg;
    assign c_coef   = c_out_reg;
    assign solvable = solv_out_reg;
    assign overflow = over_out_reg;

endmodule

// File: design/least_squares_plane_fit.sv
// Channel  Direction  Handshake            Fields
// in       input      in_valid / in_stall  x_coord, y_coord, z_coord, last_point
// out      output     out_valid / out_stall a_coef, b_coef, c_coef, solvable, overflow
//
// A point that is not the last of its set is accumulated without stalling the input.
// The last point starts a solve on the shared
// one-bit-per-cycle multiplier (36 products, each loaded, run and written back)
// and the restoring divider (one division per coefficient); a singular
// set ends after the determinant. Input is stalled during the solve.
// Reset clears all sums and flags; a waiting result does not block new points.
module least_squares_plane_fit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [lspf_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [lspf_pkg::COORD_W-1:0]   y_coord,
    input  logic signed [lspf_pkg::COORD_W-1:0]   z_coord,
    input  logic                                  last_point,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [lspf_pkg::COEF_W-1:0]    a_coef,
    output logic signed [lspf_pkg::COEF_W-1:0]    b_coef,
    output logic signed [lspf_pkg::COEF_W-1:0]    c_coef,
    output logic                                  solvable,
    output logic                                  overflow
);
    import lspf_pkg::*;

    lspf_cmd_t cmd;
    lspf_sts_t sts;

    lspf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .out_stall  (out_stall),
        .sts        (sts),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    lspf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .z_coord  (z_coord),
        .sts      (sts),
        .a_coef   (a_coef),
        .b_coef   (b_coef),
        .c_coef   (c_coef),
        .solvable (solvable),
        .overflow (overflow)
    );

endmodule

// File: design/lspf_checker.sv
`include "least_squares_plane_fit_defines.svh"

module lspf_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic signed [lspf_pkg::COORD_W-1:0]   x_coord,
    input logic signed [lspf_pkg::COORD_W-1:0]   y_coord,
    input logic signed [lspf_pkg::COORD_W-1:0]   z_coord,
    input logic                                  last_point,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [lspf_pkg::COEF_W-1:0]    a_coef,
    input logic signed [lspf_pkg::COEF_W-1:0]    b_coef,
    input logic signed [lspf_pkg::COEF_W-1:0]    c_coef,
    input logic                                  solvable,
    input logic                                  overflow
);
    import lspf_pkg::*;

    `LSPF_ASSERT_NEXT(held_result, out_valid && out_stall, out_valid && $stable(a_coef) && $stable(overflow))
    `LSPF_ASSERT_NOW(singular_zero, out_valid && !solvable, a_coef == '0 && b_coef == '0 && c_coef == '0)
    `LSPF_ASSERT_NEXT(solve_stalls, in_valid && !in_stall && last_point, in_stall)

endmodule

bind least_squares_plane_fit lspf_checker u_lspf_checker (.*);

// File: sim/least_squares_plane_fit_test.sv
`timescale 1ns / 100ps

module least_squares_plane_fit_test;
    import lspf_pkg::*;

    localparam int WIDE_W = 256;
    localparam int CYCLE_LIMIT = 6000000;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
        logic                      hold;
        logic                      calm;
    } point_t;

    typedef struct {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic                     solv;
        logic                     ovf;
    } plane_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [COORD_W-1:0] x_coord = '0;
    logic signed [COORD_W-1:0] y_coord = '0;
    logic signed [COORD_W-1:0] z_coord = '0;
    logic last_point = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [COEF_W-1:0] a_coef;
    logic signed [COEF_W-1:0] b_coef;
    logic signed [COEF_W-1:0] c_coef;
    logic solvable;
    logic overflow;

    point_t pending_points[$];
    plane_t expected_planes[$];
    logic cur_calm = 1'b0;
    int errors = 0;
    int cycles = 0;

    logic signed [SQ_W-1:0]  acc_xx, acc_xy, acc_yy, acc_xz, acc_yz;
    logic signed [LIN_W-1:0] acc_x, acc_y, acc_z;
    int unsigned acc_n;
    logic acc_dropped;

    least_squares_plane_fit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
        .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .a_coef(a_coef), .b_coef(b_coef), .c_coef(c_coef),
        .solvable(solvable), .overflow(overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic wide_t det3(input wide_t m[9]);
        return m[0] * (m[4] * m[8] - m[5] * m[7])
             - m[1] * (m[3] * m[8] - m[5] * m[6])
             + m[2] * (m[3] * m[7] - m[4] * m[6]);
    endfunction

    // Rounds num * 2^shift / den to nearest, ties away from zero, then saturates.
    function automatic logic [COEF_W-1:0] round_quotient(input wide_t num, input wide_t den,
                                                          input int shift);
        logic neg;
        wide_t n;
        wide_t d;
        wide_t q;
        wide_t limit;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        limit = neg ? wide_t'(64'h80000000) : wide_t'(64'h7FFFFFFF);
        q = ((n <<< (shift + 1)) + d) / (d <<< 1);
        if (q > limit)
            q = limit;
        return neg ? -q[COEF_W-1:0] : q[COEF_W-1:0];
    endfunction

    task automatic clear_sums();
        acc_xx = '0; acc_xy = '0; acc_yy = '0; acc_xz = '0; acc_yz = '0;
        acc_x = '0; acc_y = '0; acc_z = '0;
        acc_n = 0;
        acc_dropped = 1'b0;
    endtask

    task automatic add_point(input point_t p);
        logic signed [SQ_W-1:0] xw;
        logic signed [SQ_W-1:0] yw;
        logic signed [SQ_W-1:0] zw;
        wide_t m[9];
        wide_t rhs[3];
        wide_t cm[9];
        wide_t det;
        plane_t r;
        xw = p.x;
        yw = p.y;
        zw = p.z;
        if (acc_n < MAX_POINTS)
        begin
            acc_xx = acc_xx + xw * xw;
            acc_xy = acc_xy + xw * yw;
            acc_yy = acc_yy + yw * yw;
            acc_xz = acc_xz + xw * zw;
            acc_yz = acc_yz + yw * zw;
            acc_x = acc_x + LIN_W'(p.x);
            acc_y = acc_y + LIN_W'(p.y);
            acc_z = acc_z + LIN_W'(p.z);
            acc_n++;
        end
        else
            acc_dropped = 1'b1;
        if (!p.last)
            return;
        m[0] = acc_xx; m[1] = acc_xy; m[2] = acc_x;
        m[3] = acc_xy; m[4] = acc_yy; m[5] = acc_y;
        m[6] = acc_x;  m[7] = acc_y;  m[8] = wide_t'(acc_n);
        rhs[0] = acc_xz; rhs[1] = acc_yz; rhs[2] = acc_z;
        det = det3(m);
        r = '{a: '0, b: '0, c: '0, solv: 1'b0, ovf: acc_dropped};
        if (det != 0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 9; i++)
                    cm[i] = (i % 3 == k) ? rhs[i / 3] : m[i];
                case (k)
                    0: r.a = round_quotient(det3(cm), det, 16);
                    1: r.b = round_quotient(det3(cm), det, 16);
                    default: r.c = round_quotient(det3(cm), det, 8);
                endcase
            end
            r.solv = 1'b1;
        end
        expected_planes.push_back(r);
        clear_sums();
    endtask

    always @(posedge clk)
    begin
        point_t p;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                add_point('{x: x_coord, y: y_coord, z: z_coord, last: last_point,
                            hold: 1'b0, calm: cur_calm});
            if (!in_valid || !in_stall)
            begin
                if (pending_points.size() > 0
                    && !(pending_points[0].hold && expected_planes.size() > 0)
                    && (pending_points[0].calm || $urandom_range(99) >= 10))
                begin
                    p = pending_points.pop_front();
                    in_valid <= 1'b1;
                    x_coord <= p.x;
                    y_coord <= p.y;
                    z_coord <= p.z;
                    last_point <= p.last;
                    cur_calm <= p.calm;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        plane_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_planes.size() == 0)
                begin
                    $display("%0t: unexpected result a=%0d b=%0d c=%0d", $time,
                             a_coef, b_coef, c_coef);
                    errors++;
                end
                else
                begin
                    e = expected_planes.pop_front();
                    if (a_coef !== e.a || b_coef !== e.b || c_coef !== e.c
                        || solvable !== e.solv || overflow !== e.ovf)
                    begin
                        $display("%0t: expected a=%0d b=%0d c=%0d solvable=%0b overflow=%0b",
                                 $time, e.a, e.b, e.c, e.solv, e.ovf);
                        $display("%0t: actual   a=%0d b=%0d c=%0d solvable=%0b overflow=%0b",
                                 $time, a_coef, b_coef, c_coef, solvable, overflow);
                        errors++;
                    end
                end
            end
            out_stall <= !cur_calm && ($urandom_range(99) < 10);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("least_squares_plane_fit_test failed");
            $finish;
        end
    end

    task automatic queue_point(input int x, input int y, input int z, input logic last,
                               input logic hold = 1'b0, input logic calm = 1'b0);
        pending_points.push_back('{x: COORD_W'(x), y: COORD_W'(y), z: COORD_W'(z),
                                   last: last, hold: hold, calm: calm});
    endtask

    initial
    begin
        int sent;
        int n;
        int kind;
        int vx;
        int vy;
        logic calm;
        clear_sums();

        // A single point, then two points: both singular.
        queue_point(32767, -32768, 32767, 1'b1);
        queue_point(-32768, 32767, -32768, 1'b0);
        queue_point(32767, 32767, 0, 1'b1);
        // An exact plane.
        queue_point(0, 0, 256, 1'b0);
        queue_point(256, 0, 768, 1'b0);
        queue_point(0, 256, -256, 1'b0);
        queue_point(256, 256, 256, 1'b1);
        // Extreme heights on the unit square; the fitted slopes are zero.
        queue_point(0, 0, -32768, 1'b0);
        queue_point(1, 0, 32767, 1'b0);
        queue_point(0, 1, 32767, 1'b0);
        queue_point(1, 1, -32768, 1'b1);
        // Collinear points give a zero determinant.
        queue_point(100, 200, 5, 1'b0);
        queue_point(200, 400, -9, 1'b0);
        queue_point(-300, -600, 77, 1'b1);
        // Extreme corners.
        queue_point(-32768, -32768, -32768, 1'b0, 1'b1);
        queue_point(32767, -32768, 32767, 1'b0);
        queue_point(-32768, 32767, 32767, 1'b0);
        queue_point(32767, 32767, -32768, 1'b1);
        queue_point(0, 0, 0, 1'b1);

        sent = 0;
        while (sent < 550)
        begin
            n = $urandom_range(1, 8);
            kind = $urandom_range(9);
            calm = sent >= 200 && sent < 300;
            vx = $urandom_range(65535);
            vy = $urandom_range(65535);
            for (int i = 0; i < n; i++)
            begin
                case (kind)
                    0: queue_point(vx, $urandom_range(65535), $urandom_range(65535),
                                   i == n - 1, 1'b0, calm);
                    1: queue_point(vx, vy, $urandom_range(65535), i == n - 1, 1'b0, calm);
                    2: queue_point($urandom_range(7), $urandom_range(7),
                                   $urandom_range(65535), i == n - 1, 1'b0, calm);
                    default: queue_point($urandom_range(65535), $urandom_range(65535),
                                         $urandom_range(65535), i == n - 1,
                                         i == 0 && $urandom_range(29) == 0, calm);
                endcase
                sent++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_points.size() == 0);
        @(posedge clk);
        while (in_valid || expected_planes.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("least_squares_plane_fit_test passed");
        else
            $display("least_squares_plane_fit_test failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/lspf_pkg.sv
design/lspf_ctrl.sv
design/lspf_dp.sv
design/least_squares_plane_fit.sv
design/lspf_checker.sv
sim/least_squares_plane_fit_test.sv
